// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

  // Request codes on the input channel
  localparam logic [1:0] REQ_CHAR   = 2'd0;
  localparam logic [1:0] REQ_END    = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_OK   = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_TYPE    = 3'd0;
  localparam logic [2:0] ERR_LENGTH  = 3'd1;
  localparam logic [2:0] ERR_SUM     = 3'd2;
  localparam logic [2:0] ERR_EARLY   = 3'd3;
  localparam logic [2:0] ERR_ENDMARK = 3'd4;

  // Decoder phases
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD = 3'd2;
  localparam logic [2:0] PH_CHECK   = 3'd3;
  localparam logic [2:0] PH_ENDMARK = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;

  // Record types
  localparam logic [7:0] REC_DATA    = 8'd0;
  localparam logic [7:0] REC_EOF     = 8'd1;
  localparam logic [7:0] REC_SEGMENT = 8'd2;
  localparam logic [7:0] REC_START   = 8'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  localparam int QUEUE_DEPTH = 2;

  // Classified item passed from front to back
  typedef struct packed {
    logic [1:0] req;
    logic [3:0] nibble;
    logic       is_colon;
    logic       is_f;
  } item_t;

  // Hex digit to nibble; anything else decodes as zero
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'd87;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'd55;
      end
      nibble_of = d[3:0];
    end
  endfunction

endpackage

// ===== rtl/ihex_front.sv =====
module ihex_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [7:0]          ascii_char,
  input  logic                q_full,
  output logic                q_push,
  output ihex_pkg::item_t     q_item
);

  // Stall only when the queue has no room
  assign in_stall = q_full;

  // Classify the character; the unused request code is dropped here
  always_comb begin
    q_item.req      = req_type;
    q_item.nibble   = ihex_pkg::nibble_of(ascii_char);
    q_item.is_colon = (ascii_char == ihex_pkg::CHAR_COLON);
    q_item.is_f     = (ascii_char == ihex_pkg::CHAR_UPPER_F);
    q_push = in_valid && !q_full && (req_type != ihex_pkg::REQ_UNUSED);
  end

endmodule

// ===== rtl/ihex_queue.sv =====
module ihex_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ihex_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output ihex_pkg::item_t pop_item
);

  ihex_pkg::item_t entries [ihex_pkg::QUEUE_DEPTH];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'(ihex_pkg::QUEUE_DEPTH));
  assign not_empty = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0) else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

endmodule

// ===== rtl/ihex_back.sv =====
module ihex_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  ihex_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      result_kind,
  output logic [7:0]      data_byte,
  output logic [2:0]      error_code
);

  logic [2:0] phase, phase_next;
  logic [8:0] char_count, char_count_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic [7:0] record_length, record_length_next;
  logic [7:0] record_kind, record_kind_next;
  logic [7:0] running_sum, running_sum_next;
  logic       end_mark_seen, end_mark_seen_next;

  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic [2:0] res_code;
  logic [7:0] byte_val;
  logic [7:0] kind_sel;
  logic [7:0] need_len;
  logic [8:0] count_inc;
  logic [7:0] sum_plus;

  // Take the next item when the output slot is free or draining
  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  assign byte_val  = {high_nibble, q_item.nibble};
  assign count_inc = char_count + 9'd1;
  assign sum_plus  = running_sum + byte_val;

  // Execute one classified item
  always_comb begin
    phase_next         = phase;
    char_count_next    = char_count;
    high_nibble_next   = high_nibble;
    record_length_next = record_length;
    record_kind_next   = record_kind;
    running_sum_next   = running_sum;
    end_mark_seen_next = end_mark_seen;
    res_valid = 1'b0;
    res_kind  = ihex_pkg::KIND_DATA;
    res_byte  = 8'd0;
    res_code  = 3'd0;
    kind_sel  = (char_count == 9'd7) ? byte_val : record_kind;
    need_len  = (kind_sel == ihex_pkg::REC_SEGMENT) ? 8'd2 : 8'd4;
    if (q_pop) begin
      unique case (q_item.req)
        ihex_pkg::REQ_CLEAR: begin
          phase_next         = ihex_pkg::PH_HUNT;
          char_count_next    = 9'd0;
          high_nibble_next   = 4'd0;
          record_length_next = 8'd0;
          record_kind_next   = 8'd0;
          running_sum_next   = 8'd0;
          end_mark_seen_next = 1'b0;
        end
        ihex_pkg::REQ_END: begin
          if (phase != ihex_pkg::PH_DONE) begin
            phase_next      = ihex_pkg::PH_DONE;
            char_count_next = 9'd0;
            res_valid       = 1'b1;
            res_kind        = ihex_pkg::KIND_ERR;
            res_code        = ihex_pkg::ERR_EARLY;
          end
        end
        ihex_pkg::REQ_CHAR: begin
          if (phase == ihex_pkg::PH_DONE) begin
            // ignore text after finishing
          end else if (phase == ihex_pkg::PH_HUNT) begin
            if (q_item.is_colon) begin
              phase_next       = ihex_pkg::PH_HEADER;
              char_count_next  = 9'd0;
              running_sum_next = 8'd0;
            end
          end else if (phase == ihex_pkg::PH_ENDMARK) begin
            if (char_count == 9'd0) begin
              end_mark_seen_next = q_item.is_f;
              char_count_next    = 9'd1;
            end else begin
              phase_next      = ihex_pkg::PH_DONE;
              char_count_next = 9'd0;
              res_valid       = 1'b1;
              if (end_mark_seen && q_item.is_f) begin
                res_kind = ihex_pkg::KIND_OK;
              end else begin
                res_kind = ihex_pkg::KIND_ERR;
                res_code = ihex_pkg::ERR_ENDMARK;
              end
            end
          end else if (!char_count[0]) begin
            // first digit of a byte
            high_nibble_next = q_item.nibble;
            char_count_next  = count_inc;
          end else if (phase == ihex_pkg::PH_HEADER) begin
            if (char_count == 9'd1) record_length_next = byte_val;
            if (char_count == 9'd7) record_kind_next = byte_val;
            running_sum_next = sum_plus;
            if (char_count != 9'd7) begin
              char_count_next = count_inc;
            end else begin
              char_count_next = 9'd0;
              if (kind_sel == ihex_pkg::REC_DATA) begin
                phase_next = (record_length == 8'd0) ? ihex_pkg::PH_CHECK
                                                     : ihex_pkg::PH_PAYLOAD;
              end else if (kind_sel == ihex_pkg::REC_EOF) begin
                phase_next         = ihex_pkg::PH_ENDMARK;
                end_mark_seen_next = 1'b0;
              end else if (kind_sel inside {ihex_pkg::REC_SEGMENT, ihex_pkg::REC_START}) begin
                if (record_length != need_len) begin
                  phase_next = ihex_pkg::PH_DONE;
                  res_valid  = 1'b1;
                  res_kind   = ihex_pkg::KIND_ERR;
                  res_code   = ihex_pkg::ERR_LENGTH;
                end else begin
                  phase_next = ihex_pkg::PH_PAYLOAD;
                end
              end else begin
                phase_next = ihex_pkg::PH_DONE;
                res_valid  = 1'b1;
                res_kind   = ihex_pkg::KIND_ERR;
                res_code   = ihex_pkg::ERR_TYPE;
              end
            end
          end else if (phase == ihex_pkg::PH_PAYLOAD) begin
            running_sum_next = sum_plus;
            if ({1'b0, char_count} + 10'd1 >= {1'b0, record_length, 1'b0}) begin
              phase_next      = ihex_pkg::PH_CHECK;
              char_count_next = 9'd0;
            end else begin
              char_count_next = count_inc;
            end
            if (record_kind == ihex_pkg::REC_DATA) begin
              res_valid = 1'b1;
              res_kind  = ihex_pkg::KIND_DATA;
              res_byte  = byte_val;
            end
          end else if (phase == ihex_pkg::PH_CHECK) begin
            if (sum_plus != 8'd0) begin
              phase_next      = ihex_pkg::PH_DONE;
              char_count_next = 9'd0;
              res_valid       = 1'b1;
              res_kind        = ihex_pkg::KIND_ERR;
              res_code        = ihex_pkg::ERR_SUM;
            end else begin
              phase_next         = ihex_pkg::PH_HUNT;
              char_count_next    = 9'd0;
              high_nibble_next   = 4'd0;
              record_length_next = 8'd0;
              record_kind_next   = 8'd0;
              running_sum_next   = 8'd0;
              end_mark_seen_next = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Update decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ihex_pkg::PH_HUNT;
      char_count    <= 9'd0;
      high_nibble   <= 4'd0;
      record_length <= 8'd0;
      record_kind   <= 8'd0;
      running_sum   <= 8'd0;
      end_mark_seen <= 1'b0;
    end else begin
      phase         <= phase_next;
      char_count    <= char_count_next;
      high_nibble   <= high_nibble_next;
      record_length <= record_length_next;
      record_kind   <= record_kind_next;
      running_sum   <= running_sum_next;
      end_mark_seen <= end_mark_seen_next;
    end
  end

  // Hold the result while stalled, load a new one on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      result_kind <= res_kind;
      data_byte   <= res_byte;
      error_code  <= res_code;
    end
  end

  a_finish_to_done: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res_valid && res_kind != ihex_pkg::KIND_DATA) |=> phase == ihex_pkg::PH_DONE)
    else $error("finish result without done phase");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (q_pop && phase == ihex_pkg::PH_DONE) |-> !res_valid)
    else $error("result produced after finishing");

  a_data_from_payload: assert property (@(posedge clk) disable iff (rst)
    (q_pop && res_valid && res_kind == ihex_pkg::KIND_DATA)
      |-> (phase == ihex_pkg::PH_PAYLOAD && record_kind == ihex_pkg::REC_DATA))
    else $error("data byte outside a data record payload");

endmodule

// ===== rtl/intel_hex_to_binary_stream_core.sv =====
// Intel HEX text to binary byte stream decoder.
// An accepted character is written into the queue, and its result is registered when the back end pops it.
// Throughput: one character per cycle while the output is not stalled; the back end decodes each item combinationally.
// A two-entry queue separates the character classifier from the record decoder.
// Reset (rst, synchronous) empties the queue and output and returns to colon hunting.
module intel_hex_to_binary_stream_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] req_type,
  input  logic [7:0] ascii_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] data_byte,
  output logic [2:0] error_code
);

  ihex_pkg::item_t push_item;
  ihex_pkg::item_t pop_item;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_not_empty;

  ihex_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .ascii_char (ascii_char),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (push_item)
  );

  ihex_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  ihex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result_kind (result_kind),
    .data_byte   (data_byte),
    .error_code  (error_code)
  );

endmodule
